// ===== hdl/esc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the erf table for the erf sigmoid curve generator.
// No dependencies; esc_eval, esc_div, the top level and the bench refer to it by scoped names.
package esc_pkg;

    localparam int MAX_SAMPLES   = 1024;
    localparam int TABLE_ENTRIES = 300;
    localparam int HALF_ENTRIES  = TABLE_ENTRIES / 2;

    localparam logic [29:0] ERF_ONE   = 30'd1000000000;
    localparam logic [43:0] SAT_LIMIT = 44'd50331648;   // 3.0 in Q.24
    localparam logic [8:0]  LAST_STEP = 9'(TABLE_ENTRIES - 1);

    // Divide by 2e9 = 2^10 * 1953125: shift by 10, then multiply by the reciprocal
    // floor(2^46 / 1953125) and correct the estimate by at most two.
    localparam logic [20:0] DIV_DIVISOR    = 21'd1953125;
    localparam logic [22:0] DIV_DIVISOR_X2 = 23'd3906250;
    localparam logic [25:0] DIV_RECIP      = 26'd36028797;
    // Bias keeps the dividend positive: 2^24 * 2e9 + 1e9 (the half-up rounding term).
    localparam logic signed [56:0] DIV_BIAS = 57'sd33554433000000000;
    localparam logic signed [25:0] Q_OFFSET = 26'sd16777216;

    typedef enum logic [1:0] {
        REG_CENTER     = 2'd0,
        REG_INV_SCALE  = 2'd1,
        REG_LOW_LEVEL  = 2'd2,
        REG_HIGH_LEVEL = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic adv;   // whole pipeline advances this cycle
        logic vld;   // a transaction sits at this point
    } pipe_ctl_t;

    // erf(k/100) * 1e9, split into even and odd k so each half is read once.
    localparam logic [29:0] ERF_EVEN [HALF_ENTRIES] = '{
        0, 22564575, 45111106, 67621594, 90078126,
        112462916, 134758352, 156947033, 179011813, 200935839,
        222702589, 244295911, 265700058, 286899723, 307880068,
        328626759, 349125995, 369364529, 389329700, 409009452,
        428392352, 447467618, 466225115, 484655389, 502749670,
        520499876, 537898627, 554939245, 571615763, 587922900,
        603856090, 619411460, 634585826, 649376683, 663782195,
        677801193, 691432825, 704677825, 717536534, 730010238,
        742100790, 753810590, 765142560, 776100122, 786687219,
        796908113, 806767620, 816270948, 825423575, 834231422,
        842700735, 850837952, 858649900, 866143531, 873326119,
        880205041, 886787854, 893082302, 899096169, 904837402,
        910313960, 915533856, 920505165, 925235928, 929734183,
        934007929, 938065143, 941913707, 945561430, 949016025,
        952285112, 955376173, 958296565, 961053506, 963654059,
        966105142, 968413493, 970585687, 972628120, 974547008,
        976348380, 978038086, 979621778, 981104920, 982492786,
        983790458, 985002827, 986134593, 987190274, 988174195,
        989090501, 989943156, 990735947, 991472488, 992156222,
        992790429, 993378225, 993922570, 994426275, 994892000,
        995322265, 995719451, 996085809, 996423462, 996734409,
        997020533, 997283607, 997525293, 997747152, 997950649,
        998137154, 998307948, 998464231, 998607121, 998737661,
        998856823, 998965513, 999064570, 999154777, 999236858,
        999311486, 999379283, 999440826, 999496646, 999547236,
        999593048, 999634501, 999671979, 999705837, 999736400,
        999763966, 999788809, 999811181, 999831311, 999849409,
        999865667, 999880261, 999893351, 999905082, 999915587,
        999924987, 999933390, 999940898, 999947599, 999953576,
        999958902, 999963645, 999967866, 999971618, 999974951
    };

    localparam logic [29:0] ERF_ODD [HALF_ENTRIES] = '{
        11283416, 33841222, 56371978, 78857720, 101280594,
        123622896, 145867115, 167995971, 189992461, 211839892,
        233521923, 255022599, 276326389, 297418219, 318283496,
        338908150, 359278655, 379382053, 399205983, 418738698,
        437969090, 456886694, 475481719, 493745050, 511668260,
        529243617, 546464093, 563323359, 579815806, 595936496,
        611681217, 627046441, 642029324, 656627696, 670840052,
        684665264, 698103704, 711155430, 723821437, 736103240,
        748003138, 759523625, 770667933, 781439725, 791843127,
        801882743, 811563474, 820890718, 829870230, 838508001,
        846810448, 854784156, 862436067, 869773250, 876803068,
        883532970, 889970640, 896123821, 902000370, 907608265,
        912955492, 918050082, 922900112, 927513617, 931898615,
        936063109, 940015016, 943762189, 947312386, 950673287,
        953852432, 956857248, 959695022, 962372893, 964897859,
        967276744, 969516206, 971622731, 973602626, 975462012,
        977206834, 978842837, 980375583, 981810440, 983152586,
        984407007, 985578499, 986671670, 987690941, 988640548,
        989524544, 990346805, 991111030, 991820747, 992479318,
        993089940, 993655650, 994179333, 994663724, 995111413,
        995524849, 995906348, 996258096, 996582153, 996880460,
        997154845, 997407023, 997638607, 997851108, 998045943,
        998224438, 998387832, 998537283, 998673872, 998798606,
        998912423, 999016195, 999110733, 999196790, 999275064,
        999346202, 999410802, 999469420, 999522566, 999570712,
        999614295, 999653714, 999689340, 999721511, 999750539,
        999776711, 999800289, 999821512, 999840601, 999857757,
        999873162, 999886985, 999899378, 999910480, 999920418,
        999929307, 999937250, 999944344, 999950673, 999956316,
        999961343, 999965817, 999969797, 999973334, 999976474
    };

    localparam logic [29:0] ERF_LAST = ERF_ODD[HALF_ENTRIES - 1];

    function automatic logic [29:0] erf_even(input logic [7:0] i);
        logic [29:0] v;
        v = '0;
        if (i < 8'(HALF_ENTRIES))
        begin
            v = ERF_EVEN[i];
        end
        return v;
    endfunction

    function automatic logic [29:0] erf_odd(input logic [7:0] i);
        logic [29:0] v;
        v = '0;
        if (i < 8'(HALF_ENTRIES))
        begin
            v = ERF_ODD[i];
        end
        return v;
    endfunction

endpackage

// ===== hdl/esc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one sample index per transaction, valid/ready handshake.
// No dependencies.
interface esc_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

// ===== hdl/esc_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one curve value per transaction, valid/ready handshake.
// No dependencies.
interface esc_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] curve_value;

    modport source (output valid, output curve_value, input ready);
    modport sink   (input valid, input curve_value, output ready);
endinterface

// ===== hdl/esc_eval.sv =====
`timescale 1ns / 1ps
// Eight-stage front end: offset and scale, erf table interpolation, level mix and
// bias, giving the dividend for the divide by 2e9. Depends on esc_pkg.
module esc_eval (
    input  logic                clk,
    input  logic                rst_n,
    input  esc_pkg::pipe_ctl_t  ctl,
    input  logic [9:0]          sample_index,
    input  logic signed [19:0]  center,
    input  logic [23:0]         inv_scale,
    input  logic signed [23:0]  low_level,
    input  logic signed [23:0]  high_level,
    output logic                w_vld,
    output logic [45:0]         w
);

    logic [7:0]         vld_reg;
    logic [7:0]         vld_next;

    logic [19:0]        ad_reg;
    logic               neg1_reg;
    logic [43:0]        ax_reg;
    logic               neg2_reg;
    logic               sat_reg;
    logic [8:0]         k_reg;
    logic [23:0]        f3_reg;
    logic               neg3_reg;
    logic [29:0]        y0_reg;
    logic [23:0]        dy_reg;
    logic [23:0]        f4_reg;
    logic               neg4_reg;
    logic [47:0]        pm_reg;
    logic [29:0]        y05_reg;
    logic               neg5_reg;
    logic [30:0]        p_reg;
    logic signed [56:0] prod_reg;
    logic [45:0]        w_reg;

    logic [9:0]         idx;
    logic signed [20:0] d;
    logic [20:0]        d_abs;
    logic [32:0]        t;
    logic [7:0]         kh;
    logic [29:0]        y0;
    logic [29:0]        y1;
    logic [48:0]        pm_round;
    logic [29:0]        mag;
    logic signed [24:0] diff;
    logic signed [56:0] u;

    always_comb
    begin
        vld_next = {vld_reg[6:0], ctl.vld};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: clamp, offset from center, magnitude and sign.
    always_comb
    begin
        idx = sample_index;
        if ({1'b0, sample_index} >= 11'(esc_pkg::MAX_SAMPLES))
        begin
            idx = 10'(esc_pkg::MAX_SAMPLES - 1);
        end
        d     = $signed({3'b000, idx, 8'h00}) - $signed({center[19], center});
        d_abs = d[20] ? 21'(-d) : 21'(d);
    end

    // Stage 3: x in hundredths (table step and fraction); times 100 as shifts and adds.
    always_comb
    begin
        t = (33'(ax_reg[25:0]) << 6) + (33'(ax_reg[25:0]) << 5)
            + (33'(ax_reg[25:0]) << 2);
    end

    // Stage 4: neighboring entries come one from each half-table.
    always_comb
    begin
        kh = k_reg[8:1];
        if (k_reg[0])
        begin
            y0 = esc_pkg::erf_odd(kh);
            y1 = esc_pkg::erf_even(8'(kh + 8'd1));
        end
        else
        begin
            y0 = esc_pkg::erf_even(kh);
            y1 = esc_pkg::erf_odd(kh);
        end
    end

    always_comb
    begin
        pm_round = 49'(pm_reg) + 49'h800000;
        mag      = y05_reg + 30'(pm_round[48:24]);
        diff     = $signed({high_level[23], high_level}) - $signed({low_level[23], low_level});
        u        = prod_reg + esc_pkg::DIV_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            ad_reg   <= d_abs[19:0];
            neg1_reg <= d[20];

            ax_reg   <= 44'(ad_reg) * 44'(inv_scale);
            neg2_reg <= neg1_reg;

            sat_reg  <= ax_reg > esc_pkg::SAT_LIMIT;
            k_reg    <= t[32:24];
            f3_reg   <= t[23:0];
            neg3_reg <= neg2_reg;

            // Saturated and table-end cases force a zero slope.
            priority if (sat_reg)
            begin
                y0_reg <= esc_pkg::ERF_ONE;
                dy_reg <= '0;
            end
            else if (k_reg >= esc_pkg::LAST_STEP)
            begin
                y0_reg <= esc_pkg::ERF_LAST;
                dy_reg <= '0;
            end
            else
            begin
                y0_reg <= y0;
                dy_reg <= 24'(y1 - y0);
            end
            f4_reg   <= f3_reg;
            neg4_reg <= neg3_reg;

            pm_reg   <= 48'(dy_reg) * 48'(f4_reg);
            y05_reg  <= y0_reg;
            neg5_reg <= neg4_reg;

            p_reg    <= neg5_reg ? 31'(esc_pkg::ERF_ONE) - 31'(mag)
                                 : 31'(esc_pkg::ERF_ONE) + 31'(mag);

            prod_reg <= 57'(diff) * 57'($signed({1'b0, p_reg}));

            w_reg    <= u[55:10];
        end
    end

    assign w_vld = vld_reg[7];
    assign w     = w_reg;

endmodule

// ===== hdl/esc_div.sv =====
`timescale 1ns / 1ps
// Three-stage divide by the constant 1953125: reciprocal estimate, back-multiply,
// and a remainder check that adds at most two to the estimate. Depends on esc_pkg.
module esc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  esc_pkg::pipe_ctl_t ctl,
    input  logic [45:0]        w,
    output logic               q_vld,
    output logic [24:0]        q
);

    logic [2:0]  vld_reg;
    logic [24:0] est1_reg;
    logic [22:0] w1_reg;
    logic [24:0] est2_reg;
    logic [22:0] qd2_reg;
    logic [22:0] w2_reg;
    logic [24:0] q_reg;

    logic [51:0] est_prod;
    logic [45:0] qd_prod;
    logic [22:0] rem;
    logic [24:0] q_next;

    // The estimate never exceeds the quotient and falls short by at most two,
    // so the remainder fits in the low 23 bits.
    always_comb
    begin
        est_prod = 52'(w[45:20]) * 52'(esc_pkg::DIV_RECIP);
        qd_prod  = 46'(est1_reg) * 46'(esc_pkg::DIV_DIVISOR);
        rem      = w2_reg - qd2_reg;
        priority if (rem >= esc_pkg::DIV_DIVISOR_X2)
        begin
            q_next = est2_reg + 25'd2;
        end
        else if (rem >= 23'(esc_pkg::DIV_DIVISOR))
        begin
            q_next = est2_reg + 25'd1;
        end
        else
        begin
            q_next = est2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= {vld_reg[1:0], ctl.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            est1_reg <= est_prod[50:26];
            w1_reg   <= w[22:0];

            est2_reg <= est1_reg;
            qd2_reg  <= qd_prod[22:0];
            w2_reg   <= w1_reg;

            q_reg    <= q_next;
        end
    end

    assign q_vld = vld_reg[2];
    assign q     = q_reg;

endmodule

// ===== hdl/erf_sigmoid_curve_generator.sv =====
`timescale 1ns / 1ps
// Erf sigmoid curve generator: for each sample index returns
// low_level + (high_level - low_level) * (erf((index - center) * inv_scale) + 1) / 2,
// with erf from a 300-entry table at steps of 0.01 with linear interpolation,
// saturating to +-1 beyond |x| = 3, rounded half up and saturated to 24 bits.
// One sample index is taken every cycle unless the output stalls; each result passes
// through 8 evaluation stages, 3 stages of the divide by 2e9 by reciprocal
// multiplication, and the output register. A stall on the output
// holds the whole pipeline. Write the configuration registers (0 center Q12.8,
// 1 inv_scale Q8.16, 2 low_level, 3 high_level) only while no transaction is in
// flight.
// Depends on esc_pkg, esc_in_if, esc_out_if, esc_eval and esc_div.
module erf_sigmoid_curve_generator (
    input  logic         clk,
    input  logic         rst_n,
    esc_in_if.sink       samples,
    esc_out_if.source    curve,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    logic signed [19:0] center_reg;
    logic [23:0]        inv_scale_reg;
    logic signed [23:0] low_level_reg;
    logic signed [23:0] high_level_reg;

    logic               out_vld_reg;
    logic signed [23:0] res_reg;

    logic               adv;
    esc_pkg::pipe_ctl_t eval_ctl;
    esc_pkg::pipe_ctl_t div_ctl;
    logic               w_vld;
    logic [45:0]        w;
    logic               q_vld;
    logic [24:0]        q;
    logic signed [26:0] sum;
    logic signed [23:0] res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg     <= '0;
            inv_scale_reg  <= 24'd65536;
            low_level_reg  <= '0;
            high_level_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (esc_pkg::reg_index_t'(cfg_index))
                esc_pkg::REG_CENTER:     center_reg     <= cfg_data[19:0];
                esc_pkg::REG_INV_SCALE:  inv_scale_reg  <= cfg_data;
                esc_pkg::REG_LOW_LEVEL:  low_level_reg  <= cfg_data;
                esc_pkg::REG_HIGH_LEVEL: high_level_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance everything unless a finished result is held by the sink.
    assign adv           = !out_vld_reg || curve.ready;
    assign samples.ready = adv;

    assign eval_ctl.adv = adv;
    assign eval_ctl.vld = samples.valid;
    assign div_ctl.adv  = adv;
    assign div_ctl.vld  = w_vld;

    esc_eval u_eval (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (eval_ctl),
        .sample_index (samples.sample_index),
        .center       (center_reg),
        .inv_scale    (inv_scale_reg),
        .low_level    (low_level_reg),
        .high_level   (high_level_reg),
        .w_vld        (w_vld),
        .w            (w)
    );

    esc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .w     (w),
        .q_vld (q_vld),
        .q     (q)
    );

    // Remove the divider bias, add the low level, clip to 24 bits.
    always_comb
    begin
        sum = 27'($signed({1'b0, q}) - esc_pkg::Q_OFFSET)
              + 27'(low_level_reg);
        priority if (sum > 27'sd8388607)
        begin
            res_next = 24'sh7FFFFF;
        end
        else if (sum < -27'sd8388608)
        begin
            res_next = 24'sh800000;
        end
        else
        begin
            res_next = sum[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= q_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign curve.valid       = out_vld_reg;
    assign curve.curve_value = res_reg;

endmodule

// ===== tb/sv/erf_sigmoid_curve_generator_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the erf sigmoid curve generator: random handshake gaps,
// register sweeps and a bit-true curve predictor with an in-order result queue.
// Depends on esc_pkg, esc_in_if, esc_out_if and erf_sigmoid_curve_generator.

class curve_scoreboard;
    logic signed [23:0] pending_values[$];
    int mismatches;
    int checked;

    function void note_sample(logic signed [23:0] value);
        pending_values.push_back(value);
    endfunction

    function void check_value(logic signed [23:0] actual);
        logic signed [23:0] want;
        if (pending_values.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected curve value %0d", actual);
            return;
        end
        want = pending_values.pop_front();
        checked++;
        if (want !== actual)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("curve value mismatch: expected %0d actual %0d", want, actual);
        end
    endfunction
endclass

module erf_sigmoid_curve_generator_test;

    localparam longint ONE_E9 = 64'd1000000000;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [23:0] cfg_data;

    esc_in_if samples ();
    esc_out_if curve ();

    erf_sigmoid_curve_generator dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples.sink),
        .curve(curve.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    curve_scoreboard board;

    longint center_q8;
    longint inv_scale_q16;
    longint low_lvl;
    longint high_lvl;
    longint erf_points[esc_pkg::TABLE_ENTRIES];

    int busy_pct_in;
    int busy_pct_out;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint floor_divide(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic logic signed [23:0] predict_curve(logic [9:0] idx);
        longint d;
        longint ad;
        longint ax;
        longint t;
        longint k;
        longint f;
        longint mag;
        longint erf_v;
        longint res;
        d = longint'(idx) * 256 - center_q8;
        ad = (d < 0) ? -d : d;
        ax = ad * inv_scale_q16;
        if (ax > (longint'(3) << 24))
            mag = ONE_E9;
        else
        begin
            t = ax * 100;
            k = t >>> 24;
            f = t & ((longint'(1) << 24) - 1);
            if (k >= esc_pkg::TABLE_ENTRIES - 1)
                mag = erf_points[esc_pkg::TABLE_ENTRIES - 1];
            else
                mag = erf_points[k] + (((erf_points[k + 1] - erf_points[k]) * f
                      + (longint'(1) << 23)) >>> 24);
        end
        erf_v = (d < 0) ? -mag : mag;
        res = low_lvl + floor_divide((high_lvl - low_lvl) * (erf_v + ONE_E9) + ONE_E9,
                                     2 * ONE_E9);
        if (res > 8388607)
            res = 8388607;
        if (res < -8388608)
            res = -8388608;
        return 24'(res);
    endfunction

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(esc_pkg::reg_index_t which, logic [23:0] value);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(posedge clk);
        case (which)
            esc_pkg::REG_CENTER:     center_q8 = longint'($signed(value[19:0]));
            esc_pkg::REG_INV_SCALE:  inv_scale_q16 = longint'(value);
            esc_pkg::REG_LOW_LEVEL:  low_lvl = longint'($signed(value));
            esc_pkg::REG_HIGH_LEVEL: high_lvl = longint'($signed(value));
            default: ;
        endcase
    endtask

    task automatic load_curve(logic [19:0] c, logic [23:0] s, logic [23:0] lo, logic [23:0] hi);
        write_reg(esc_pkg::REG_CENTER, 24'(c));
        write_reg(esc_pkg::REG_INV_SCALE, s);
        write_reg(esc_pkg::REG_LOW_LEVEL, lo);
        write_reg(esc_pkg::REG_HIGH_LEVEL, hi);
        cfg_we <= 1'b0;
    endtask

    // Hold until every expected value is back, then let the pipe drain.
    task automatic drain_results();
        while (board.pending_values.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_sample(logic [9:0] idx);
        while ($urandom_range(99) < busy_pct_in)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid <= 1'b1;
        samples.sample_index <= idx;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        board.note_sample(predict_curve(idx));
    endtask

    task automatic stop_sending();
        samples.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: accept and check at each edge.
    always @(posedge clk)
    begin
        if (rst_n && curve.valid && curve.ready)
            board.check_value(curve.curve_value);
        if (rst_n)
            curve.ready <= ($urandom_range(99) >= busy_pct_out);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [9:0] pick_index();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 10'd0;
        if (r == 1)
            return 10'd1023;
        if (r < 5)
            return 10'(($urandom_range(64) + (center_q8 >>> 8) - 32) & 10'h3FF);
        return 10'($urandom);
    endfunction

    initial
    begin
        int i;
        int ph;
        logic [23:0] lo;
        logic [23:0] hi;
        erf_points = '{
            0, 11283416, 22564575, 33841222, 45111106, 56371978, 67621594, 78857720, 90078126,
            101280594, 112462916, 123622896, 134758352, 145867115, 156947033, 167995971,
            179011813, 189992461, 200935839, 211839892, 222702589, 233521923, 244295911,
            255022599, 265700058, 276326389, 286899723, 297418219, 307880068, 318283496,
            328626759, 338908150, 349125995, 359278655, 369364529, 379382053, 389329700,
            399205983, 409009452, 418738698, 428392352, 437969090, 447467618, 456886694,
            466225115, 475481719, 484655389, 493745050, 502749670, 511668260, 520499876,
            529243617, 537898627, 546464093, 554939245, 563323359, 571615763, 579815806,
            587922900, 595936496, 603856090, 611681217, 619411460, 627046441, 634585826,
            642029324, 649376683, 656627696, 663782195, 670840052, 677801193, 684665264,
            691432825, 698103704, 704677825, 711155430, 717536534, 723821437, 730010238,
            736103240, 742100790, 748003138, 753810590, 759523625, 765142560, 770667933,
            776100122, 781439725, 786687219, 791843127, 796908113, 801882743, 806767620,
            811563474, 816270948, 820890718, 825423575, 829870230, 834231422, 838508001,
            842700735, 846810448, 850837952, 854784156, 858649900, 862436067, 866143531,
            869773250, 873326119, 876803068, 880205041, 883532970, 886787854, 889970640,
            893082302, 896123821, 899096169, 902000370, 904837402, 907608265, 910313960,
            912955492, 915533856, 918050082, 920505165, 922900112, 925235928, 927513617,
            929734183, 931898615, 934007929, 936063109, 938065143, 940015016, 941913707,
            943762189, 945561430, 947312386, 949016025, 950673287, 952285112, 953852432,
            955376173, 956857248, 958296565, 959695022, 961053506, 962372893, 963654059,
            964897859, 966105142, 967276744, 968413493, 969516206, 970585687, 971622731,
            972628120, 973602626, 974547008, 975462012, 976348380, 977206834, 978038086,
            978842837, 979621778, 980375583, 981104920, 981810440, 982492786, 983152586,
            983790458, 984407007, 985002827, 985578499, 986134593, 986671670, 987190274,
            987690941, 988174195, 988640548, 989090501, 989524544, 989943156, 990346805,
            990735947, 991111030, 991472488, 991820747, 992156222, 992479318, 992790429,
            993089940, 993378225, 993655650, 993922570, 994179333, 994426275, 994663724,
            994892000, 995111413, 995322265, 995524849, 995719451, 995906348, 996085809,
            996258096, 996423462, 996582153, 996734409, 996880460, 997020533, 997154845,
            997283607, 997407023, 997525293, 997638607, 997747152, 997851108, 997950649,
            998045943, 998137154, 998224438, 998307948, 998387832, 998464231, 998537283,
            998607121, 998673872, 998737661, 998798606, 998856823, 998912423, 998965513,
            999016195, 999064570, 999110733, 999154777, 999196790, 999236858, 999275064,
            999311486, 999346202, 999379283, 999410802, 999440826, 999469420, 999496646,
            999522566, 999547236, 999570712, 999593048, 999614295, 999634501, 999653714,
            999671979, 999689340, 999705837, 999721511, 999736400, 999750539, 999763966,
            999776711, 999788809, 999800289, 999811181, 999821512, 999831311, 999840601,
            999849409, 999857757, 999865667, 999873162, 999880261, 999886985, 999893351,
            999899378, 999905082, 999910480, 999915587, 999920418, 999924987, 999929307,
            999933390, 999937250, 999940898, 999944344, 999947599, 999950673, 999953576,
            999956316, 999958902, 999961343, 999963645, 999965817, 999967866, 999969797,
            999971618, 999973334, 999974951, 999976474
        };
        board = new();
        center_q8 = 0;
        inv_scale_q16 = 65536;
        low_lvl = 0;
        high_lvl = 0;
        busy_pct_in = 33;
        busy_pct_out = 33;
        cycle_count = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = esc_pkg::REG_CENTER;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.sample_index = '0;
        curve.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: flat curve at zero.
        send_sample(10'd0);
        send_sample(10'd1023);
        stop_sending();
        drain_results();

        // Directed: center 512, unit scale, full-range levels.
        load_curve(20'd131072, 24'd65536, 24'h800000, 24'h7FFFFF);
        send_sample(10'd0);
        send_sample(10'd512);
        send_sample(10'd511);
        send_sample(10'd513);
        send_sample(10'd514);   // |x| = 2, interpolation
        send_sample(10'd515);   // |x| = 3, table end
        send_sample(10'd509);
        send_sample(10'd1023);  // beyond three
        stop_sending();
        drain_results();

        // Quarter steps from 2.5 to 3.5, through three and past it.
        load_curve(20'd0, 24'd16384, 24'd0, 24'd8000000);
        for (i = 10; i <= 14; i++)
            send_sample(10'(i));
        stop_sending();
        drain_results();

        // Zero scale, reversed levels, negative center extreme, max scale.
        load_curve(20'h80000, 24'd0, 24'h7FFFFF, 24'h800000);
        send_sample(10'd0);
        send_sample(10'd1023);
        stop_sending();
        drain_results();
        load_curve(20'h7FFFF, 24'hFFFFFF, 24'd1000, 24'hFFFC18);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1022);
        stop_sending();
        drain_results();

        // Random phases of register settings.
        for (ph = 0; ph < 11; ph++)
        begin
            lo = $urandom;
            hi = $urandom;
            if (ph % 3 == 0)
            begin
                lo = 24'($signed($urandom_range(2000)) - 1000);
                hi = 24'($signed($urandom_range(2000000)));
            end
            load_curve(20'($urandom_range(1023) * 256 + $urandom_range(255)),
                       (ph % 4 == 1) ? 24'($urandom) : 24'($urandom_range(200000)),
                       lo, hi);
            busy_pct_in = (ph == 5) ? 0 : 33;
            busy_pct_out = (ph == 5) ? 0 : 33;
            for (i = 0; i < 50; i++)
                send_sample(pick_index());
            stop_sending();
            drain_results();
        end

        if (board.mismatches == 0 && board.pending_values.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
